/* rtl/core/b58_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and the character table of the base-58 encoder.
package b58_pkg;

  localparam int ByteW  = 8;
  localparam int DigitW = 6;
  localparam int CharW  = 7;
  localparam int AccW   = DigitW + ByteW;

  localparam int Radix = 58;

  // acc / 58 == (acc * 1130) >> 16, exact for acc below 58 * 256
  localparam int RecipW = 11;
  localparam logic [RecipW-1:0] Recip58 = 11'd1130;
  localparam int RecipShift = 16;
  localparam int ProdW = AccW + RecipW;

  // at most this many characters per message
  localparam int ResultCap = 45;
  localparam int CapW      = 6;

  localparam logic [CharW-1:0] CharOne = 7'h31;

  localparam logic [8*Radix-1:0] AlphabetStr =
    "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

  function automatic logic [CharW-1:0] b58_char(input logic [DigitW-1:0] d);
    logic [7:0] c;
    c = 8'h00;
    if (d < DigitW'(Radix)) begin
      c = AlphabetStr[8*(Radix-1-int'(d)) +: 8];
    end
    return c[CharW-1:0];
  endfunction

endpackage

/* rtl/core/b58_if.sv */
`timescale 1ns / 1ps
// Valid/ready channels for message bytes and encoded characters.
interface b58_byte_if;
  logic                     valid;
  logic                     ready;
  logic [b58_pkg::ByteW-1:0] data_byte;
  logic                     last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface b58_char_if;
  logic                     valid;
  logic                     ready;
  logic [b58_pkg::CharW-1:0] out_char;
  logic                     out_last;
  logic                     overflow_error;

  modport source (output valid, out_char, out_last, overflow_error, input ready);
  modport sink   (input valid, out_char, out_last, overflow_error, output ready);
endinterface

/* rtl/core/b58_cell.sv */
`timescale 1ns / 1ps
// One base-58 digit of the store: folds a carry wavefront, shifts, clears.
module b58_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  b58_pkg::cell_ctrl_t       ctrl,
  input  logic                      tok_in,
  input  logic [b58_pkg::ByteW-1:0]  carry_in,
  input  logic [b58_pkg::DigitW-1:0] digit_in,
  output logic [b58_pkg::DigitW-1:0] digit,
  output logic                      tok_out,
  output logic [b58_pkg::ByteW-1:0]  carry_out
);
  import b58_pkg::*;

  logic [AccW-1:0]   acc;
  logic [ProdW-1:0]  prod;
  logic [ByteW-1:0]  quo;
  logic [AccW-1:0]   rem_full;
  logic [DigitW-1:0] rem;

  // acc = digit * 256 + carry, always below 58 * 256
  assign acc      = {digit, {ByteW{1'b0}}} + {{DigitW{1'b0}}, carry_in};
  assign prod     = {{RecipW{1'b0}}, acc} * {{AccW{1'b0}}, Recip58};
  assign quo      = prod[RecipShift +: ByteW];
  assign rem_full = acc - ({{DigitW{1'b0}}, quo} * AccW'(Radix));
  assign rem      = rem_full[DigitW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      digit   <= '0;
      tok_out <= 1'b0;
    end else if (ctrl.clear) begin
      digit   <= '0;
      tok_out <= 1'b0;
    end else begin
      tok_out <= tok_in;
      if (ctrl.shift) begin
        digit <= digit_in;
      end else if (tok_in) begin
        digit <= rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in) begin
      carry_out <= quo;
    end
  end

endmodule

/* rtl/core/base58_encoder.sv */
`timescale 1ns / 1ps
// Base-58 (Bitcoin alphabet) encoder with a systolic row of digit cells.
// Message bytes are taken one per cycle, most significant first; each nonzero
// or later byte launches a carry wavefront into the least significant cell,
// which moves one cell per cycle, so bytes may follow back to back. After the
// last byte the block waits for the last wavefront to leave the most
// significant cell, then shifts the row toward the top one digit per cycle to
// skip leading zero digits, then sends one '1' per leading zero byte and one
// character per remaining digit, one per cycle while the sink is ready. No new
// message is accepted until the final character has been loaded into the
// output register. A message longer than MAX_BYTES gives a single item with
// overflow_error set.
module base58_encoder #(
  parameter int MAX_BYTES = 32,
  parameter int DIGITS    = 45
) (
  input logic        clk,
  input logic        rst,
  b58_byte_if.sink   msg,
  b58_char_if.source enc
);
  import b58_pkg::*;

  localparam int CntW  = $clog2(MAX_BYTES + 2);
  localparam int LzW   = $clog2(MAX_BYTES + 1);
  localparam int LeftW = $clog2(DIGITS + 1);

  localparam logic [2:0] S_ACC   = 3'd0;
  localparam logic [2:0] S_DRAIN = 3'd1;
  localparam logic [2:0] S_SKIP  = 3'd2;
  localparam logic [2:0] S_ONES  = 3'd3;
  localparam logic [2:0] S_DIGS  = 3'd4;
  localparam logic [2:0] S_ERR   = 3'd5;

  logic [2:0]       state;
  logic [CntW-1:0]  byte_count;
  logic [LzW-1:0]   lz;
  logic             past;
  logic [LeftW-1:0] left;
  logic [CapW-1:0]  n;

  logic             o_valid;
  logic [CharW-1:0] o_char;
  logic             o_last;
  logic             o_err;

  logic              tok   [DIGITS:0];
  logic [ByteW-1:0]  carry [DIGITS:1];
  logic [DigitW-1:0] dig   [DIGITS:0];
  logic [DIGITS-1:0] tok_vec;

  cell_ctrl_t       ctrl;
  logic             accept;
  logic             in_range;
  logic             fold;
  logic             busy;
  logic             load;
  logic             last_ones;
  logic             last_dig;
  logic             emit;
  logic             finish;
  logic [CharW-1:0] e_char;
  logic             e_last;
  logic             e_err;

  assign msg.ready = (state == S_ACC);
  assign accept    = msg.valid && msg.ready;
  assign in_range  = (byte_count < CntW'(MAX_BYTES));
  assign fold      = accept && in_range && (past || (msg.data_byte != '0));

  assign tok[DIGITS]   = fold;
  assign carry[DIGITS] = msg.data_byte;
  assign dig[DIGITS]   = '0;

  for (genvar i = 0; i < DIGITS; i++) begin : g_cell
    assign tok_vec[i] = tok[i];
    if (i == 0) begin : g_msd
      // carry out of the top digit is dropped
      b58_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .tok_in    (tok[1]),
        .carry_in  (carry[1]),
        .digit_in  (dig[1]),
        .digit     (dig[0]),
        .tok_out   (tok[0]),
        .carry_out ()
      );
    end else begin : g_low
      b58_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .tok_in    (tok[i+1]),
        .carry_in  (carry[i+1]),
        .digit_in  (dig[i+1]),
        .digit     (dig[i]),
        .tok_out   (tok[i]),
        .carry_out (carry[i])
      );
    end
  end

  assign busy      = |tok_vec;
  assign load      = !o_valid || enc.ready;
  assign last_ones = ((lz == LzW'(1)) && (left == '0)) || (n == CapW'(ResultCap - 1));
  assign last_dig  = (left == LeftW'(1)) || (n == CapW'(ResultCap - 1));

  always_comb begin
    ctrl   = '0;
    emit   = 1'b0;
    finish = 1'b0;
    e_char = '0;
    e_last = 1'b0;
    e_err  = 1'b0;
    unique case (state)
      S_ACC: begin
        // overflowed message: drop the store, wavefronts included
        if (accept && msg.last_byte && !in_range) begin
          ctrl.clear = 1'b1;
        end
      end
      S_DRAIN: begin
      end
      S_SKIP: begin
        if ((left != '0) && (dig[0] == '0)) begin
          ctrl.shift = 1'b1;
        end
      end
      S_ONES: begin
        if (lz == '0) begin
          finish = (left == '0);
        end else if (load) begin
          emit   = 1'b1;
          e_char = CharOne;
          e_last = last_ones;
          finish = last_ones;
        end
      end
      S_DIGS: begin
        if (left == '0) begin
          finish = 1'b1;
        end else if (load) begin
          emit       = 1'b1;
          e_char     = b58_char(dig[0]);
          e_last     = last_dig;
          ctrl.shift = 1'b1;
          finish     = last_dig;
        end
      end
      S_ERR: begin
        if (load) begin
          emit   = 1'b1;
          e_last = 1'b1;
          e_err  = 1'b1;
          finish = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (finish) begin
      ctrl.clear = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_ACC;
      byte_count <= '0;
      lz         <= '0;
      past       <= 1'b0;
      left       <= '0;
      n          <= '0;
      o_valid    <= 1'b0;
    end else begin
      if (emit) begin
        o_valid <= 1'b1;
      end else if (enc.ready) begin
        o_valid <= 1'b0;
      end
      if (finish) begin
        state      <= S_ACC;
        byte_count <= '0;
        lz         <= '0;
        past       <= 1'b0;
        n          <= '0;
      end else begin
        unique case (state)
          S_ACC: begin
            if (accept) begin
              if (in_range) begin
                byte_count <= byte_count + CntW'(1);
                if (!past && (msg.data_byte == '0)) begin
                  lz <= lz + LzW'(1);
                end else begin
                  past <= 1'b1;
                end
              end else begin
                byte_count <= CntW'(MAX_BYTES + 1);
              end
              if (msg.last_byte) begin
                state <= in_range ? S_DRAIN : S_ERR;
              end
            end
          end
          S_DRAIN: begin
            if (!busy) begin
              state <= S_SKIP;
              left  <= LeftW'(DIGITS);
            end
          end
          S_SKIP: begin
            if (ctrl.shift) begin
              left <= left - LeftW'(1);
            end else begin
              state <= S_ONES;
            end
          end
          S_ONES: begin
            if (emit) begin
              lz <= lz - LzW'(1);
              n  <= n + CapW'(1);
            end else if (lz == '0) begin
              state <= S_DIGS;
            end
          end
          S_DIGS: begin
            if (emit) begin
              left <= left - LeftW'(1);
              n    <= n + CapW'(1);
            end
          end
          S_ERR: begin
          end
          default: begin
            state <= S_ACC;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_char <= e_char;
      o_last <= e_last;
      o_err  <= e_err;
    end
  end

  assign enc.valid          = o_valid;
  assign enc.out_char       = o_char;
  assign enc.out_last       = o_last;
  assign enc.overflow_error = o_err;

endmodule

/* rtl/core/b58_checker.sv */
`timescale 1ns / 1ps
// Port-level checks of the base-58 encoder, bound to the top level.
module b58_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      msg_ready,
  input logic                      enc_valid,
  input logic                      enc_ready,
  input logic [b58_pkg::CharW-1:0] out_char,
  input logic                      out_last,
  input logic                      overflow_error
);
  import b58_pkg::*;

  // error item is alone and carries no character
  a_err_form: assert property (@(posedge clk) disable iff (rst)
    enc_valid && overflow_error |-> (out_char == '0) && out_last)
    else $error("overflow item malformed");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    enc_valid && !overflow_error |-> (out_char >= CharOne) && (out_char <= 7'h7a))
    else $error("character outside alphabet range");

  // no new message is taken while a string is still being sent
  a_no_take_mid: assert property (@(posedge clk) disable iff (rst)
    enc_valid && !out_last |-> !msg_ready)
    else $error("input ready in the middle of a string");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    enc_valid && !enc_ready |=> enc_valid && $stable(out_char) && $stable(out_last)
                                && $stable(overflow_error))
    else $error("stalled item changed");

endmodule

bind base58_encoder b58_checker u_b58_checker (
  .clk            (clk),
  .rst            (rst),
  .msg_ready      (msg.ready),
  .enc_valid      (enc.valid),
  .enc_ready      (enc.ready),
  .out_char       (enc.out_char),
  .out_last       (enc.out_last),
  .overflow_error (enc.overflow_error)
);
